### design/medpr_pkg.sv
// ---------------------------------------------------------------------------
// medpr_pkg - shared types, constants and functions
// Register codes, field widths, zigzag decode and median edge predictor.
// ---------------------------------------------------------------------------
package medpr_pkg;

	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam int PIXEL_W      = 16;
	localparam int BYTE_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(4096);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef logic [PIXEL_W-1:0] pixel_t;

	// scan position flags of one pixel
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic eoi;
	} pos_t;

	// even code v -> v/2, odd code v -> -(v+1)/2 = ~(v>>1)
	function automatic pixel_t zigzag_decode(input pixel_t code);
		pixel_t half;
		half = {1'b0, code[PIXEL_W-1:1]};
		zigzag_decode = code[0] ? ~half : half;
	endfunction

	// a + b - c clamped between min(a,b) and max(a,b)
	function automatic pixel_t med_predict(input pixel_t a, input pixel_t b, input pixel_t c);
		pixel_t             lo;
		pixel_t             hi;
		logic [PIXEL_W:0]   s;
		logic [PIXEL_W:0]   lo_c;
		logic [PIXEL_W:0]   hi_c;
		lo   = (a < b) ? a : b;
		hi   = (a < b) ? b : a;
		s    = {1'b0, a} + {1'b0, b};
		lo_c = {1'b0, lo} + {1'b0, c};
		hi_c = {1'b0, hi} + {1'b0, c};
		if (s < lo_c) begin
			med_predict = lo;
		end else if (s > hi_c) begin
			med_predict = hi;
		end else begin
			med_predict = PIXEL_W'(s - {1'b0, c});
		end
	endfunction

endpackage

### design/medpr_if.sv
// ---------------------------------------------------------------------------
// medpr_if - channel interfaces
// Residual request channel, pixel result channel and register write channel.
// ---------------------------------------------------------------------------
interface medpr_res_if;
	logic                           valid;
	logic                           ready;
	logic [medpr_pkg::BYTE_W-1:0]   residual_high;
	logic [medpr_pkg::BYTE_W-1:0]   residual_low;

	modport source (output valid, residual_high, residual_low, input ready);
	modport sink   (input valid, residual_high, residual_low, output ready);
endinterface

interface medpr_pix_if;
	logic                           valid;
	logic                           ready;
	logic [medpr_pkg::PIXEL_W-1:0]  pixel;
	logic                           end_of_image;

	modport source (output valid, pixel, end_of_image, input ready);
	modport sink   (input valid, pixel, end_of_image, output ready);
endinterface

interface medpr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [medpr_pkg::CFG_IDX_W-1:0]  index;
	logic [medpr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/medpr_ram.sv
// ---------------------------------------------------------------------------
// medpr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ---------------------------------------------------------------------------
module medpr_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 4096,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/medpr_pos.sv
// ---------------------------------------------------------------------------
// medpr_pos - raster scan position
// Column and row counters, advanced once per accepted residual request.
// ---------------------------------------------------------------------------
module medpr_pos #(
	parameter  int MAX_WIDTH = 4096,
	localparam int XW        = $clog2(MAX_WIDTH)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic [medpr_pkg::WIDTH_REG_W-1:0]      image_width,
	input  logic [medpr_pkg::HEIGHT_REG_W-1:0]     image_height,
	output logic [XW-1:0]                          x,
	output medpr_pkg::pos_t                        pos
);
	import medpr_pkg::*;

	localparam int CMPW = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;

	logic [XW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [CMPW-1:0]         w_ext;
	logic [CMPW-1:0]         w_eff;
	logic [CMPW-1:0]         x_next;
	logic [HEIGHT_REG_W:0]   h_eff;
	logic [HEIGHT_REG_W:0]   row_next;
	logic                    last_col;
	logic                    last_row;

	always_comb begin
		w_ext = CMPW'(image_width);
		if (w_ext == '0) begin
			w_eff = CMPW'(1);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff    = (image_height == '0) ? (HEIGHT_REG_W + 1)'(1) : {1'b0, image_height};
		x_next   = CMPW'(col_q) + CMPW'(1);
		row_next = {1'b0, row_q} + (HEIGHT_REG_W + 1)'(1);
		// a width lowered mid-image ends the row at once
		last_col = (x_next >= w_eff);
		last_row = (row_next >= h_eff);
	end

	assign x             = col_q;
	assign pos.first_row = (row_q == '0);
	assign pos.first_col = (col_q == '0);
	assign pos.eoi       = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[HEIGHT_REG_W-1:0];
			end else begin
				col_q <= x_next[XW-1:0];
			end
		end
	end
endmodule

### design/median_edge_pixel_reconstruct.sv
// ---------------------------------------------------------------------------
// median_edge_pixel_reconstruct - median edge predictor, decode side
// Rebuilds 16-bit pixels from zigzag residual bytes using a previous-row store.
// ---------------------------------------------------------------------------
// Usage:
//   residual : one request per pixel in raster order, high and low residual
//              byte together. Accepted when valid and ready are both high.
//   recon    : one result per request: the pixel and an end_of_image flag on
//              the last pixel of the image, after which the scan restarts.
//   cfg      : register writes (index 0 image_width, index 1 image_height),
//              always ready out of reset; write only while no pixel is in flight.
// Timing: an accepted request is registered in the predict stage, then in the
//   output register when it is empty or recon is ready. One pixel per cycle
//   sustained while recon is ready; the line store is read at the accept edge
//   and written when the pixel leaves the predict stage, with the pending
//   write forwarded when both hit the same column.
// Stall: a result waits in the output register; one more pixel may sit in the
//   predict stage, after which residual.ready drops until recon drains.
// Reset: position, neighbors, pipeline and registers clear (width 4096,
//   height 1); the line store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module median_edge_pixel_reconstruct #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	medpr_cfg_if.sink   cfg,
	medpr_res_if.sink   residual,
	medpr_pix_if.source recon
);
	import medpr_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	logic          in_acc;
	logic          s1_adv;
	logic [XW-1:0] x_rd;
	pos_t          pos_rd;
	pixel_t        ram_q;

	logic          v_s1;
	logic [XW-1:0] x_s1;
	pos_t          pos_s1;
	pixel_t        code_s1;
	logic          fwd_s1;
	pixel_t        fwd_pix_s1;

	pixel_t        above;
	pixel_t        pred;
	pixel_t        pix;
	pixel_t        left_q;
	pixel_t        upleft_q;

	logic          out_v_q;
	pixel_t        pix_q;
	logic          eoi_q;

	// register writes
	assign cfg.ready = arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_adv         = v_s1 && (!out_v_q || recon.ready);
	assign residual.ready = arst_n && (!v_s1 || s1_adv);
	assign in_acc         = residual.valid && residual.ready;

	medpr_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (in_acc),
		.image_width (width_q),
		.image_height(height_q),
		.x           (x_rd),
		.pos         (pos_rd)
	);

	medpr_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(x_s1),
		.wdata(pix),
		.re   (in_acc),
		.raddr(x_rd),
		.rdata(ram_q)
	);

	// predict stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1       <= x_rd;
			pos_s1     <= pos_rd;
			code_s1    <= {residual.residual_high, residual.residual_low};
			// RAM returns old data when the write in flight hits the same column
			fwd_s1     <= v_s1 && (x_s1 == x_rd);
			fwd_pix_s1 <= pix;
		end
	end

	always_comb begin
		above = fwd_s1 ? fwd_pix_s1 : ram_q;
		priority if (pos_s1.first_row) begin
			pred = pos_s1.first_col ? '0 : left_q;
		end else if (pos_s1.first_col) begin
			pred = above;
		end else begin
			pred = med_predict(left_q, above, upleft_q);
		end
		pix = pred + zigzag_decode(code_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_adv) begin
			left_q   <= pix;
			upleft_q <= above;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (recon.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pix_q <= pix;
			eoi_q <= pos_s1.eoi;
		end
	end

	assign recon.valid        = out_v_q;
	assign recon.pixel        = pix_q;
	assign recon.end_of_image = eoi_q;
endmodule

### design/medpr_checker.sv
// ---------------------------------------------------------------------------
// medpr_checker - port-level checks for the pixel reconstructor
// Latency, backpressure and reset behavior seen at the top-level channels.
// ---------------------------------------------------------------------------
module medpr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [medpr_pkg::PIXEL_W-1:0]  out_pixel,
	input logic                           out_eoi
);
	import medpr_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_eoi))
		else $error("result changed while stalled");

	// a fresh result comes from a request that passed the predict stage and output register
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("result without a matching request");

	// requests are refused only when both stages are full and stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused with room in the pipeline");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");
endmodule

bind median_edge_pixel_reconstruct medpr_checker u_medpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (residual.valid),
	.in_ready (residual.ready),
	.out_valid(recon.valid),
	.out_ready(recon.ready),
	.out_pixel(recon.pixel),
	.out_eoi  (recon.end_of_image)
);

### dv/median_edge_pixel_reconstruct_tb.sv
// ---------------------------------------------------------------------------
// median_edge_pixel_reconstruct_tb - pixel reconstruction testbench
// Drives zigzag residual requests in raster order, predicts every pixel and
// end-of-image flag with its own median edge predictor and line store, and
// checks the result stream in order. Covers register extremes, mid-image
// register changes, an oversize width and random image shapes with
// random idling on both sides plus a long receiver hold-off.
// ---------------------------------------------------------------------------
module median_edge_pixel_reconstruct_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import medpr_pkg::*;

	localparam int LINE_DEPTH     = 4096;
	localparam int RANDOM_ITEMS   = 380;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct {
		logic [BYTE_W-1:0] high;
		logic [BYTE_W-1:0] low;
	} residual_req_t;

	typedef struct {
		pixel_t pix;
		logic   eoi;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;

	medpr_res_if res_if ();
	medpr_pix_if pix_if ();
	medpr_cfg_if cfg_if ();

	median_edge_pixel_reconstruct DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_if),
		.residual (res_if),
		.recon    (pix_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	pixel_t                 line_mem [LINE_DEPTH];
	pixel_t                 left_px;
	pixel_t                 upleft_px;
	int                     img_col;
	int                     img_row;
	logic [WIDTH_REG_W-1:0]  cfg_width;
	logic [HEIGHT_REG_W-1:0] cfg_height;

	residual_req_t pending_residuals [$];
	pixel_result_t expected_pixels [$];

	int  reqs_queued;
	int  reqs_accepted;
	int  results_seen;
	int  eoi_seen;
	int  reg_writes;
	int  err_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_left;
	int  idle_cycles;
	bit  hold_request;
	bit  res_taken;

	function automatic int eff_width();
		int w;
		w = int'(cfg_width);
		if (w == 0) w = 1;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		return w;
	endfunction

	function automatic int eff_height();
		return (cfg_height == 0) ? 1 : int'(cfg_height);
	endfunction

	function automatic pixel_t decode_residual(input pixel_t code);
		int mag;
		mag = code[0] ? -((int'(code) + 1) >>> 1) : (int'(code) >>> 1);
		return pixel_t'(mag);
	endfunction

	// left + above - upper-left, clamped between left and above
	function automatic pixel_t median_edge(input pixel_t a, input pixel_t b, input pixel_t c);
		int lo;
		int hi;
		int s;
		lo = (a < b) ? int'(a) : int'(b);
		hi = (a < b) ? int'(b) : int'(a);
		s  = int'(a) + int'(b) - int'(c);
		if (s < lo) return pixel_t'(lo);
		if (s > hi) return pixel_t'(hi);
		return pixel_t'(s);
	endfunction

	task automatic reconstruct_pixel(input logic [BYTE_W-1:0] code_hi,
			input logic [BYTE_W-1:0] code_lo, output pixel_result_t res);
		int     w;
		int     h;
		int     x;
		pixel_t above;
		pixel_t pred;
		logic   last_col;
		logic   last_row;
		w = eff_width();
		h = eff_height();
		x = (img_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : img_col;
		above = line_mem[x];
		if (img_row == 0) begin
			pred = (x == 0) ? '0 : left_px;
		end else if (x == 0) begin
			pred = above;
		end else begin
			pred = median_edge(left_px, above, upleft_px);
		end
		res.pix = pred + decode_residual({code_hi, code_lo});
		upleft_px   = above;
		line_mem[x] = res.pix;
		left_px     = res.pix;
		last_col = (x + 1 >= w);
		last_row = (img_row + 1 >= h);
		res.eoi  = last_col && last_row;
		if (last_col) begin
			img_col = 0;
			img_row = last_row ? 0 : ((img_row + 1) & 16'hFFFF);
		end else begin
			img_col = x + 1;
		end
	endtask

	// requests still needed to reach the end of the current image
	function automatic int pixels_left_in_image();
		int w;
		int h;
		int cur;
		w = eff_width();
		h = eff_height();
		cur = (img_col + 1 >= w) ? 1 : w - img_col;
		return cur + ((img_row + 1 >= h) ? 0 : (h - img_row - 1) * w);
	endfunction

	function automatic residual_req_t random_residual();
		residual_req_t r;
		logic [15:0]   code;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: code = 16'($urandom_range(0, 31));
			6, 7:             code = 16'($urandom);
			8:                code = 16'hFFFF - 16'($urandom_range(0, 15));
			default:          code = 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
		endcase
		r.high = code[15:8];
		r.low  = code[7:0];
		return r;
	endfunction

	// driver: residual requests, launched at the falling edge
	always @(negedge clk) begin : drive_residuals
		residual_req_t req;
		if (!arst_n) begin
			res_if.valid <= 1'b0;
		end else if (!res_if.valid || res_taken) begin
			res_taken = 1'b0;
			if (pending_residuals.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req = pending_residuals.pop_front();
				res_if.valid         <= 1'b1;
				res_if.residual_high <= req.high;
				res_if.residual_low  <= req.low;
			end else begin
				res_if.valid         <= 1'b0;
				res_if.residual_high <= 8'($urandom);
				res_if.residual_low  <= 8'($urandom);
			end
		end
	end

	always @(negedge clk) begin : drive_recon_ready
		if (!arst_n) begin
			pix_if.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
			pix_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			pix_if.ready <= 1'b0;
		end else begin
			pix_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted pixels
	always @(posedge clk) begin : watch_channels
		pixel_result_t e;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				res_taken = 1'b1;
				reqs_accepted++;
				reconstruct_pixel(res_if.residual_high, res_if.residual_low, e);
				expected_pixels.push_back(e);
			end
			if (pix_if.valid && pix_if.ready) begin
				results_seen++;
				if (pix_if.end_of_image) eoi_seen++;
				if (expected_pixels.size() == 0) begin
					err_count++;
					$display("%0t: unexpected pixel: expected none, actual %h eoi %b",
						$time, pix_if.pixel, pix_if.end_of_image);
				end else begin
					e = expected_pixels.pop_front();
					if (pix_if.pixel !== e.pix) begin
						err_count++;
						$display("%0t: pixel mismatch: expected %h, actual %h",
							$time, e.pix, pix_if.pixel);
					end
					if (pix_if.end_of_image !== e.eoi) begin
						err_count++;
						$display("%0t: end_of_image mismatch: expected %b, actual %b",
							$time, e.eoi, pix_if.end_of_image);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((res_if.valid && res_if.ready) || (pix_if.valid && pix_if.ready)
					|| (cfg_if.valid && cfg_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		if (idx == REG_IMAGE_WIDTH) begin
			cfg_width = cfg_if.data[WIDTH_REG_W-1:0];
		end else begin
			cfg_height = cfg_if.data[HEIGHT_REG_W-1:0];
		end
		reg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
		cfg_if.data  = 16'($urandom);
		@(posedge clk);
	endtask

	task automatic push_code(input logic [15:0] code);
		residual_req_t r;
		r.high = code[15:8];
		r.low  = code[7:0];
		pending_residuals.push_back(r);
		reqs_queued++;
	endtask

	task automatic queue_random(input int n);
		repeat (n) begin
			pending_residuals.push_back(random_residual());
			reqs_queued++;
		end
	endtask

	task automatic drain();
		while (reqs_accepted != reqs_queued || expected_pixels.size() != 0) @(posedge clk);
	endtask

	// one image at position zero; optionally cut short by lowering a register
	task automatic run_image(input int w, input int h, input bit cut_short);
		int total;
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		total = pixels_left_in_image();
		if (cut_short && total > 1) begin
			queue_random($urandom_range(1, total - 1));
			drain();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_WIDTH, $urandom_range(0, eff_width()));
			end else begin
				write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, eff_height()));
			end
		end
		queue_random(pixels_left_in_image());
		drain();
	endtask

	initial begin : stimulus
		int random_base;
		int w;
		int h;
		int sel;
		res_if.valid         = 1'b0;
		res_if.residual_high = '0;
		res_if.residual_low  = '0;
		pix_if.ready         = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = REG_IMAGE_WIDTH;
		cfg_if.data          = '0;
		foreach (line_mem[i]) line_mem[i] = '0;
		left_px    = '0;
		upleft_px  = '0;
		img_col    = 0;
		img_row    = 0;
		cfg_width  = WIDTH_RESET;
		cfg_height = HEIGHT_RESET;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset registers: first pixel, first row, extreme codes
		push_code(16'h0000);
		push_code(16'hFFFF);
		push_code(16'h0001);
		push_code(16'hFFFE);
		push_code(16'h8000);
		push_code(16'h7FFF);
		drain();
		// width zero mid-row: column already past the width, row and image end
		write_reg(REG_IMAGE_WIDTH, 0);
		queue_random(pixels_left_in_image());
		drain();
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		queue_random(9);
		drain();
		// upper data bits dropped by the width register; height zero
		write_reg(REG_IMAGE_WIDTH, 16'h2003);
		write_reg(REG_IMAGE_HEIGHT, 0);
		queue_random(3);
		drain();
		// max height, then lowered below the current row
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 65535);
		queue_random(5);
		drain();
		write_reg(REG_IMAGE_HEIGHT, 3);
		queue_random(pixels_left_in_image());
		drain();

		// oversize width, then narrowed mid-row; receiver held off to fill the pipe
		write_reg(REG_IMAGE_WIDTH, 8191);
		write_reg(REG_IMAGE_HEIGHT, 2);
		hold_request = 1'b1;
		queue_random(40);
		drain();
		write_reg(REG_IMAGE_WIDTH, 5);
		queue_random(pixels_left_in_image());
		drain();

		random_base = reqs_queued;
		while (reqs_queued - random_base < RANDOM_ITEMS) begin
			case ((reqs_queued - random_base) * 4 / RANDOM_ITEMS)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct  = 10;
					recv_stall_pct = 10;
				end
			endcase
			sel = $urandom_range(0, 19);
			if (sel < 15) begin
				w = $urandom_range(1, 12);
			end else if (sel < 19) begin
				w = $urandom_range(13, 40);
			end else begin
				w = $urandom_range(0, 1);
			end
			h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
			run_image(w, h, $urandom_range(0, 4) == 0);
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
		end
		$display("Run: %0d residual requests, %0d pixels checked, %0d image ends, %0d reg writes",
			reqs_accepted, results_seen, eoi_seen, reg_writes);
		$display("Shapes: reset size, width 0/1/3/4096+, height 0/65535, mid-image cuts; %0d errors",
			err_count);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
